FILE: design/skhct_pkg.sv
// ----------------------------------------------------------------------------
// skhct_pkg
// shared types, codes and constants of the string key hash counter table
// ----------------------------------------------------------------------------
package skhct_pkg;

    localparam int TABLE_SLOTS_DEF   = 59;
    localparam int KEY_BYTES_MAX_DEF = 19;

    localparam logic [63:0] HASH_SEED  = 64'd5381;
    localparam int          HASH_SHIFT = 5;
    localparam int          PROBE_STEP = 7;
    localparam logic [15:0] COUNT_MAX  = 16'hFFFF;
    localparam logic [31:0] COLL_MAX   = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        ST_NEW   = 3'd0,
        ST_INC   = 3'd1,
        ST_FOUND = 3'd2,
        ST_MISS  = 3'd3,
        ST_FULL  = 3'd4,
        ST_BAD   = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MOD,
        S_HOME,
        S_PRB_RD,
        S_PRB_CK,
        S_CMP_RD,
        S_CMP_CK,
        S_NEXT,
        S_COPY,
        S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic    hash_en;
        logic    key_clear;
        logic    mod_start;
        logic    mod_step;
        logic    probe_start;
        logic    probe_rd;
        logic    probe_next;
        logic    cmp_start;
        logic    cmp_rd;
        logic    cmp_next;
        logic    copy_wr;
        logic    ins_new;
        logic    inc_wr;
        logic    res_load;
        t_status res_code;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic in_bad;
        logic is_lookup;
        logic mod_last;
        logic slot_empty;
        logic len_eq;
        logic byte_eq;
        logic j_last;
        logic probe_end;
    } t_dp_sts;

endpackage

FILE: design/skhct_if.sv
// ----------------------------------------------------------------------------
// skhct channel interfaces
// key byte request channel and result request channel
// ----------------------------------------------------------------------------
interface skhct_key_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] key_byte;
    logic       key_last;

    modport source (output valid, output cmd, output key_byte, output key_last,
                    input ready);
    modport sink   (input valid, input cmd, input key_byte, input key_last,
                    output ready);
endinterface

interface skhct_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [5:0]  slot_index;
    logic [15:0] entry_count;
    logic [31:0] collision_total;
    logic [5:0]  term_total;

    modport source (output valid, output status, output slot_index,
                    output entry_count, output collision_total,
                    output term_total, input ready);
    modport sink   (input valid, input status, input slot_index,
                    input entry_count, input collision_total,
                    input term_total, output ready);
endinterface

FILE: design/skhct_dp.sv
// ----------------------------------------------------------------------------
// skhct_dp
// hash, modulo reduction, probe address, key compare and slot storage
// ----------------------------------------------------------------------------
module skhct_dp #(
    parameter int TABLE_SLOTS   = skhct_pkg::TABLE_SLOTS_DEF,
    parameter int KEY_BYTES_MAX = skhct_pkg::KEY_BYTES_MAX_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  skhct_pkg::t_dp_cmd  i_cmd,
    output skhct_pkg::t_dp_sts  o_sts,
    input  logic                i_cmd_bit,
    input  logic [7:0]          i_key_byte,
    output logic [2:0]          o_status,
    output logic [5:0]          o_slot_index,
    output logic [15:0]         o_entry_count,
    output logic [31:0]         o_collision_total,
    output logic [5:0]          o_term_total
);

    localparam int IW = $clog2(TABLE_SLOTS);
    localparam int LW = $clog2(KEY_BYTES_MAX + 1);
    localparam int JW = $clog2(KEY_BYTES_MAX);
    localparam int AW = $clog2(TABLE_SLOTS * KEY_BYTES_MAX);
    localparam int PW = IW + 4;
    localparam int SW = (IW > 6) ? IW : 6;
    localparam int TW = (IW + 1 > 6) ? IW + 1 : 6;
    // byte-wise reduction: remainder and one hash byte, reciprocal of the table size
    localparam int XW = IW + 8;
    localparam int RS = XW + IW;
    localparam logic [63:0] RECIP = ((64'd1 << RS) + 64'(TABLE_SLOTS) - 64'd1)
                                    / 64'(TABLE_SLOTS);

    typedef enum logic [1:0] {PH_HOME, PH_UP, PH_LOW} t_phase;

    // key receive
    logic [7:0]    r_key_buf [KEY_BYTES_MAX];
    logic [LW-1:0] r_key_len;
    logic          r_key_ovf;
    logic [63:0]   r_hash;
    logic          r_cmd;

    // modulo and probe
    logic [IW-1:0] r_rem;
    logic [5:0]    r_mod_cnt;
    logic [IW-1:0] r_home;
    logic [IW-1:0] r_idx;
    t_phase        r_phase;
    logic [AW-1:0] r_base;
    logic [LW-1:0] r_j;

    // table storage
    logic [7:0]             r_slot_mem [TABLE_SLOTS * KEY_BYTES_MAX];
    logic [LW-1:0]          r_len_mem  [TABLE_SLOTS];
    logic [15:0]            r_cnt_mem  [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0] r_valid;
    logic [LW-1:0]          r_len_q;
    logic [15:0]            r_cnt_q;
    logic [7:0]             r_byte_q;

    // running totals and result
    logic [31:0]        r_coll;
    logic [TW-1:0]      r_terms;
    skhct_pkg::t_status r_status;
    logic [SW-1:0]      r_slot;
    logic [15:0]        r_count;

    logic            w_byte_bad;
    logic [63:0]     n_hash;
    logic [XW-1:0]   w_mx;
    logic [2*XW+1:0] w_prod;
    logic [7:0]      w_quo;
    logic [XW-1:0]   w_mr;
    logic [IW-1:0]   n_rem;
    logic [PW-1:0]   w_cand;
    logic [IW-1:0]   n_idx;
    t_phase          n_phase;
    logic            w_end;
    logic [AW-1:0]   w_addr;
    logic [15:0]     w_cnt_inc;

    assign w_byte_bad = (i_key_byte == 8'd0) || (r_key_len >= LW'(KEY_BYTES_MAX));
    assign n_hash = (r_hash << skhct_pkg::HASH_SHIFT) + r_hash + {56'd0, i_key_byte};

    // one byte of the hash per step, quotient by reciprocal multiply is exact
    assign w_mx   = {r_rem, r_hash[63:56]};
    assign w_prod = (2*XW+2)'(w_mx) * (2*XW+2)'(RECIP);
    assign w_quo  = w_prod[RS+7:RS];
    assign w_mr   = w_mx - XW'(w_quo) * XW'(TABLE_SLOTS);
    assign n_rem  = w_mr[IW-1:0];

    // next slot of the probe sequence
    always_comb begin
        if (r_phase == PH_HOME) begin
            w_cand = PW'(r_home) + PW'(1);
        end else begin
            w_cand = PW'(r_idx) + PW'(skhct_pkg::PROBE_STEP);
        end
        if (r_phase != PH_LOW) begin
            if (w_cand < PW'(TABLE_SLOTS)) begin
                n_idx   = w_cand[IW-1:0];
                n_phase = PH_UP;
                w_end   = 1'b0;
            end else begin
                n_idx   = '0;
                n_phase = PH_LOW;
                w_end   = (r_home == '0);
            end
        end else begin
            n_idx   = w_cand[IW-1:0];
            n_phase = PH_LOW;
            w_end   = (w_cand >= PW'(r_home));
        end
    end

    assign w_addr    = r_base + AW'(r_j);
    assign w_cnt_inc = (r_cnt_q == skhct_pkg::COUNT_MAX) ? r_cnt_q : r_cnt_q + 16'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_len <= '0;
            r_key_ovf <= 1'b0;
            r_hash    <= skhct_pkg::HASH_SEED;
            r_valid   <= '0;
            r_coll    <= '0;
            r_terms   <= '0;
        end else begin
            if (i_cmd.hash_en) begin
                r_hash <= n_hash;
                if (w_byte_bad) begin
                    r_key_ovf <= 1'b1;
                end else begin
                    r_key_len <= r_key_len + LW'(1);
                end
            end else if (i_cmd.key_clear) begin
                r_key_len <= '0;
                r_key_ovf <= 1'b0;
                r_hash    <= skhct_pkg::HASH_SEED;
            end else if (i_cmd.mod_step) begin
                r_hash <= r_hash << 8;
            end
            if (i_cmd.probe_next && r_coll != skhct_pkg::COLL_MAX) begin
                r_coll <= r_coll + 32'd1;
            end
            if (i_cmd.ins_new) begin
                r_valid[r_idx] <= 1'b1;
                r_terms        <= r_terms + TW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.hash_en) begin
            r_cmd <= i_cmd_bit;
            if (!w_byte_bad) begin
                r_key_buf[r_key_len[JW-1:0]] <= i_key_byte;
            end
        end
        if (i_cmd.mod_start) begin
            r_rem     <= '0;
            r_mod_cnt <= '0;
        end else if (i_cmd.mod_step) begin
            r_rem     <= n_rem;
            r_mod_cnt <= r_mod_cnt + 6'd1;
        end
        if (i_cmd.probe_start) begin
            r_home  <= r_rem;
            r_idx   <= r_rem;
            r_phase <= PH_HOME;
            r_base  <= AW'(r_rem) * AW'(KEY_BYTES_MAX);
        end else if (i_cmd.probe_next) begin
            r_idx   <= n_idx;
            r_phase <= n_phase;
            r_base  <= AW'(n_idx) * AW'(KEY_BYTES_MAX);
        end
        if (i_cmd.cmp_start) begin
            r_j <= '0;
        end else if (i_cmd.cmp_next || i_cmd.copy_wr) begin
            r_j <= r_j + LW'(1);
        end
        if (i_cmd.probe_rd) begin
            r_len_q <= r_len_mem[r_idx];
            r_cnt_q <= r_cnt_mem[r_idx];
        end
        if (i_cmd.cmp_rd) begin
            r_byte_q <= r_slot_mem[w_addr];
        end
        if (i_cmd.copy_wr) begin
            r_slot_mem[w_addr] <= r_key_buf[r_j[JW-1:0]];
        end
        if (i_cmd.ins_new) begin
            r_len_mem[r_idx] <= r_key_len;
            r_cnt_mem[r_idx] <= 16'd1;
        end else if (i_cmd.inc_wr) begin
            r_cnt_mem[r_idx] <= w_cnt_inc;
        end
        if (i_cmd.res_load) begin
            r_status <= i_cmd.res_code;
            case (i_cmd.res_code)
                skhct_pkg::ST_NEW: begin
                    r_slot  <= SW'(r_idx);
                    r_count <= 16'd1;
                end
                skhct_pkg::ST_INC: begin
                    r_slot  <= SW'(r_idx);
                    r_count <= w_cnt_inc;
                end
                skhct_pkg::ST_FOUND: begin
                    r_slot  <= SW'(r_idx);
                    r_count <= r_cnt_q;
                end
                default: begin
                    r_slot  <= '0;
                    r_count <= '0;
                end
            endcase
        end
    end

    assign o_sts.in_bad     = r_key_ovf || w_byte_bad;
    assign o_sts.is_lookup  = r_cmd;
    assign o_sts.mod_last   = (r_mod_cnt == 6'd7);
    assign o_sts.slot_empty = !r_valid[r_idx];
    assign o_sts.len_eq     = (r_len_q == r_key_len);
    assign o_sts.byte_eq    = (r_byte_q == r_key_buf[r_j[JW-1:0]]);
    assign o_sts.j_last     = ((r_j + LW'(1)) == r_key_len);
    assign o_sts.probe_end  = w_end;

    assign o_status          = r_status;
    assign o_slot_index      = r_slot[5:0];
    assign o_entry_count     = r_count;
    assign o_collision_total = r_coll;
    assign o_term_total      = r_terms[5:0];

endmodule

FILE: design/skhct_ctrl.sv
// ----------------------------------------------------------------------------
// skhct_ctrl
// sequencer for key receive, reduction, probing, compare, copy and result
// ----------------------------------------------------------------------------
module skhct_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_last,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output skhct_pkg::t_dp_cmd o_cmd,
    input  skhct_pkg::t_dp_sts i_sts
);

    skhct_pkg::t_state r_state;
    skhct_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= skhct_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_cmd.res_code = skhct_pkg::ST_BAD;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            skhct_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.hash_en = 1'b1;
                    if (i_in_last) begin
                        if (i_sts.in_bad) begin
                            o_cmd.res_load = 1'b1;
                            o_cmd.res_code = skhct_pkg::ST_BAD;
                            n_state        = skhct_pkg::S_OUT;
                        end else begin
                            o_cmd.mod_start = 1'b1;
                            n_state         = skhct_pkg::S_MOD;
                        end
                    end
                end
            end
            skhct_pkg::S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_sts.mod_last) begin
                    n_state = skhct_pkg::S_HOME;
                end
            end
            skhct_pkg::S_HOME: begin
                o_cmd.probe_start = 1'b1;
                n_state           = skhct_pkg::S_PRB_RD;
            end
            skhct_pkg::S_PRB_RD: begin
                o_cmd.probe_rd = 1'b1;
                n_state        = skhct_pkg::S_PRB_CK;
            end
            skhct_pkg::S_PRB_CK: begin
                if (i_sts.slot_empty) begin
                    if (i_sts.is_lookup) begin
                        o_cmd.res_load = 1'b1;
                        o_cmd.res_code = skhct_pkg::ST_MISS;
                        n_state        = skhct_pkg::S_OUT;
                    end else begin
                        o_cmd.cmp_start = 1'b1;
                        n_state         = skhct_pkg::S_COPY;
                    end
                end else if (!i_sts.len_eq) begin
                    n_state = skhct_pkg::S_NEXT;
                end else begin
                    o_cmd.cmp_start = 1'b1;
                    n_state         = skhct_pkg::S_CMP_RD;
                end
            end
            skhct_pkg::S_CMP_RD: begin
                o_cmd.cmp_rd = 1'b1;
                n_state      = skhct_pkg::S_CMP_CK;
            end
            skhct_pkg::S_CMP_CK: begin
                if (!i_sts.byte_eq) begin
                    n_state = skhct_pkg::S_NEXT;
                end else if (i_sts.j_last) begin
                    o_cmd.res_load = 1'b1;
                    if (i_sts.is_lookup) begin
                        o_cmd.res_code = skhct_pkg::ST_FOUND;
                    end else begin
                        o_cmd.res_code = skhct_pkg::ST_INC;
                        o_cmd.inc_wr   = 1'b1;
                    end
                    n_state = skhct_pkg::S_OUT;
                end else begin
                    o_cmd.cmp_next = 1'b1;
                    n_state        = skhct_pkg::S_CMP_RD;
                end
            end
            skhct_pkg::S_NEXT: begin
                o_cmd.probe_next = 1'b1;
                if (i_sts.probe_end) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_code = i_sts.is_lookup ? skhct_pkg::ST_MISS
                                                     : skhct_pkg::ST_FULL;
                    n_state        = skhct_pkg::S_OUT;
                end else begin
                    n_state = skhct_pkg::S_PRB_RD;
                end
            end
            skhct_pkg::S_COPY: begin
                o_cmd.copy_wr = 1'b1;
                if (i_sts.j_last) begin
                    o_cmd.ins_new  = 1'b1;
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_code = skhct_pkg::ST_NEW;
                    n_state        = skhct_pkg::S_OUT;
                end
            end
            skhct_pkg::S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.key_clear = 1'b1;
                    n_state         = skhct_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = skhct_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: design/string_key_hash_counter_table.sv
// ----------------------------------------------------------------------------
// string_key_hash_counter_table
// counts string keys in an open addressed table keyed by a 64-bit djb2 hash
// ----------------------------------------------------------------------------
//  channel   | dir | payload                                         | request
//  i_key     | in  | cmd, key_byte, key_last                         | one key byte
//  o_res     | out | status, slot_index, entry_count,                | one result
//            |     | collision_total, term_total                     | per last byte
//
//  a byte that is not the last is taken in S_IDLE; the last byte adds the
//  byte-wise modulo of the hash (S_MOD) and the home slot (S_HOME), then a
//  read and a check per probed slot (S_PRB_RD, S_PRB_CK), S_NEXT per failed
//  one, a read and a check per compared byte (one port on the key store),
//  S_COPY per byte to store a new key, then S_OUT to show the result
//  reset clears the occupied bits of all slots at once; no clearing pass
//  a stalled result holds o_res and keeps i_key.ready low until taken
// ----------------------------------------------------------------------------
module string_key_hash_counter_table #(
    parameter int TABLE_SLOTS   = skhct_pkg::TABLE_SLOTS_DEF,
    parameter int KEY_BYTES_MAX = skhct_pkg::KEY_BYTES_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    skhct_key_if.sink   i_key,
    skhct_res_if.source o_res
);

    // command and status between the sequencer and the datapath
    skhct_pkg::t_dp_cmd w_cmd;
    skhct_pkg::t_dp_sts w_sts;

    skhct_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_key.valid),
        .i_in_last   (i_key.key_last),
        .o_in_ready  (i_key.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    // hash, probe and table storage
    skhct_dp #(
        .TABLE_SLOTS   (TABLE_SLOTS),
        .KEY_BYTES_MAX (KEY_BYTES_MAX)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_cmd_bit         (i_key.cmd),
        .i_key_byte        (i_key.key_byte),
        .o_status          (o_res.status),
        .o_slot_index      (o_res.slot_index),
        .o_entry_count     (o_res.entry_count),
        .o_collision_total (o_res.collision_total),
        .o_term_total      (o_res.term_total)
    );

    // never take a byte while a result is shown
    a_no_overlap : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_key.ready && o_res.valid))
        else $error("key byte accepted while result pending");

    // a last byte closes the input until its result is taken
    a_last_blocks : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_key.valid && i_key.ready && i_key.key_last) |=> !i_key.ready)
        else $error("input reopened right after last byte");

    // the collision total never goes down
    a_coll_mono : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (o_res.collision_total >= $past(o_res.collision_total)))
        else $error("collision total decreased");

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// drives key byte requests into the hash counter table, predicts each result
// with a behavioral table model and checks every result request field by field
// ----------------------------------------------------------------------------
module tb_top;

    localparam int SLOTS    = skhct_pkg::TABLE_SLOTS_DEF;
    localparam int KMAX     = skhct_pkg::KEY_BYTES_MAX_DEF;
    localparam int LIMIT    = 2_000_000;

    typedef struct packed {
        logic       cmd;
        logic [7:0] key_byte;
        logic       key_last;
    } t_key_req;

    typedef struct packed {
        skhct_pkg::t_status status;
        logic [5:0]         slot_index;
        logic [15:0]        entry_count;
        logic [31:0]        collision_total;
        logic [5:0]         term_total;
    } t_result;

    logic i_clk;
    logic i_rst_n;

    skhct_key_if key_ch ();
    skhct_res_if res_ch ();

    string_key_hash_counter_table dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_key  (key_ch.sink),
        .o_res  (res_ch.source)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // table model: own copy of the stored keys and counters
    // ------------------------------------------------------------------
    logic [7:0]  tbl_key   [SLOTS][KMAX];
    int          tbl_len   [SLOTS];
    logic [15:0] tbl_count [SLOTS];
    logic [31:0] coll_cnt;
    int          term_cnt;
    logic [7:0]  cur_key   [KMAX];
    int          cur_len;
    bit          cur_bad;
    logic [63:0] cur_hash;

    t_result expected_results[$];
    t_key_req pending_reqs[$];
    int       error_count;

    function automatic bit slot_matches(int s);
        if (tbl_len[s] == 0) return 1'b1;
        if (tbl_len[s] != cur_len) return 1'b0;
        for (int j = 0; j < cur_len; j++)
            if (tbl_key[s][j] != cur_key[j]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic void bump_collisions();
        if (coll_cnt != skhct_pkg::COLL_MAX) coll_cnt++;
    endfunction

    // follows one accepted key byte; queues a result on the last byte
    task automatic predict_table(input t_key_req r);
        t_result res;
        int home;
        int hit;
        if (r.key_byte == 8'd0 || cur_len >= KMAX) cur_bad = 1'b1;
        else begin
            cur_key[cur_len] = r.key_byte;
            cur_len++;
        end
        cur_hash = (cur_hash << skhct_pkg::HASH_SHIFT) + cur_hash + 64'(r.key_byte);
        if (!r.key_last) return;
        res = '0;
        if (cur_bad || cur_len == 0) res.status = skhct_pkg::ST_BAD;
        else begin
            home = int'(cur_hash % 64'(SLOTS));
            hit = -1;
            // home, then from home + 1 upward stepping by 7, then from 0 below home
            if (slot_matches(home)) hit = home;
            else begin
                bump_collisions();
                for (int i = home + 1; i < SLOTS && hit < 0; i += skhct_pkg::PROBE_STEP) begin
                    if (slot_matches(i)) hit = i;
                    else bump_collisions();
                end
                for (int i = 0; i < home && hit < 0; i += skhct_pkg::PROBE_STEP) begin
                    if (slot_matches(i)) hit = i;
                    else bump_collisions();
                end
            end
            if (hit < 0) res.status = r.cmd ? skhct_pkg::ST_MISS : skhct_pkg::ST_FULL;
            else if (tbl_len[hit] == 0) begin
                if (!r.cmd) begin
                    for (int j = 0; j < cur_len; j++) tbl_key[hit][j] = cur_key[j];
                    tbl_len[hit] = cur_len;
                    tbl_count[hit] = 16'd1;
                    term_cnt++;
                    res.status = skhct_pkg::ST_NEW;
                    res.slot_index = 6'(hit);
                    res.entry_count = 16'd1;
                end else res.status = skhct_pkg::ST_MISS;
            end else begin
                if (!r.cmd) begin
                    if (tbl_count[hit] != skhct_pkg::COUNT_MAX) tbl_count[hit]++;
                    res.status = skhct_pkg::ST_INC;
                end else res.status = skhct_pkg::ST_FOUND;
                res.slot_index = 6'(hit);
                res.entry_count = tbl_count[hit];
            end
        end
        res.collision_total = coll_cnt;
        res.term_total = 6'(term_cnt);
        expected_results.push_back(res);
        cur_len = 0;
        cur_bad = 1'b0;
        cur_hash = skhct_pkg::HASH_SEED;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // stimulus generation
    // ------------------------------------------------------------------
    logic [7:0] vocab[16][$];
    int         vocab_n;

    task automatic push_key(input logic [7:0] bytes[$], input logic cmd);
        foreach (bytes[k])
            pending_reqs.push_back('{cmd: (k == bytes.size() - 1) ? cmd : ~cmd,
                                     key_byte: bytes[k],
                                     key_last: k == bytes.size() - 1});
    endtask

    function automatic void make_word(output logic [7:0] w[$], input int len);
        w = {};
        for (int k = 0; k < len; k++) w.push_back(8'($urandom_range(1, 255)));
    endfunction

    initial begin
        logic [7:0] w[$];
        int pick;
        error_count = 0;
        coll_cnt = '0;
        term_cnt = 0;
        cur_len = 0;
        cur_bad = 1'b0;
        cur_hash = skhct_pkg::HASH_SEED;
        for (int s = 0; s < SLOTS; s++) begin
            tbl_len[s] = 0;
            tbl_count[s] = '0;
        end

        // directed: empty key, zero byte inside, extremes, over-long, lookups
        push_key('{8'd0}, 1'b0);
        push_key('{8'd0}, 1'b1);
        push_key('{8'd65, 8'd0, 8'd66}, 1'b0);
        push_key('{8'd255}, 1'b0);
        push_key('{8'd1}, 1'b0);
        push_key('{8'd255}, 1'b0);
        push_key('{8'd255}, 1'b1);
        push_key('{8'd2}, 1'b1);
        make_word(w, KMAX);
        push_key(w, 1'b0);
        push_key(w, 1'b1);
        make_word(w, KMAX + 1);
        push_key(w, 1'b0);

        // random: a small vocabulary so counts repeat, with noise keys
        vocab_n = 16;
        for (int v = 0; v < vocab_n; v++) make_word(vocab[v], $urandom_range(1, 6));
        while (pending_reqs.size() < 480) begin
            pick = $urandom_range(0, 19);
            if (pick < 14) push_key(vocab[$urandom_range(0, vocab_n - 1)], 1'($urandom_range(0, 3) == 0));
            else if (pick < 18) begin
                make_word(w, $urandom_range(1, 4));
                push_key(w, 1'($urandom_range(0, 1)));
            end else if (pick == 18) begin
                make_word(w, $urandom_range(1, KMAX + 2));
                w[$urandom_range(0, w.size() - 1)] = 8'd0;
                push_key(w, 1'($urandom));
            end else begin
                make_word(w, $urandom_range(KMAX - 2, KMAX + 3));
                push_key(w, 1'($urandom));
            end
        end
        // fill the table to force full and long probe chains
        while (pending_reqs.size() < 680) begin
            make_word(w, $urandom_range(1, 3));
            push_key(w, 1'($urandom_range(0, 4) == 0));
        end
        for (int k = 0; k < 20; k++)
            push_key(vocab[$urandom_range(0, vocab_n - 1)], 1'($urandom));
    end

    // ------------------------------------------------------------------
    // reset, sender and receiver
    // ------------------------------------------------------------------
    int  rst_cycles;
    int  burst_left;
    int  gap_left;
    int  stall_pat;
    int  hold_left;
    bit  hold_done;
    int  accepted;
    int  cycle_cnt;
    int  drain_cnt;

    initial begin
        i_rst_n = 1'b0;
        key_ch.valid = 1'b0;
        key_ch.cmd = 1'b0;
        key_ch.key_byte = '0;
        key_ch.key_last = 1'b0;
        res_ch.ready = 1'b0;
        rst_cycles = 0;
        burst_left = 0;
        gap_left = 0;
        stall_pat = 0;
        hold_left = 0;
        hold_done = 1'b0;
        accepted = 0;
        cycle_cnt = 0;
        drain_cnt = 0;
    end

    always @(posedge i_clk) begin
        if (rst_cycles < 3) begin
            rst_cycles <= rst_cycles + 1;
            i_rst_n <= (rst_cycles == 2);
        end
    end

    // sender: bursts of random length, random gaps between them
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (key_ch.valid && key_ch.ready) begin
                predict_table('{key_ch.cmd, key_ch.key_byte, key_ch.key_last});
                accepted <= accepted + 1;
            end
            if (!key_ch.valid || key_ch.ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    key_ch.valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    t_key_req nxt;
                    nxt = pending_reqs.pop_front();
                    key_ch.valid <= 1'b1;
                    key_ch.cmd <= nxt.cmd;
                    key_ch.key_byte <= nxt.key_byte;
                    key_ch.key_last <= nxt.key_last;
                    if (burst_left > 0) burst_left <= burst_left - 1;
                    else begin
                        burst_left <= $urandom_range(0, 30);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end else key_ch.valid <= 1'b0;
            end
        end
    end

    // receiver: its own stall pattern plus one long hold-off mid run
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            stall_pat <= stall_pat + 1;
            if (!hold_done && accepted > 300) begin
                hold_done <= 1'b1;
                hold_left <= 400;
                res_ch.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                res_ch.ready <= (hold_left == 1);
            end else if (stall_pat[9]) res_ch.ready <= 1'b1;
            else res_ch.ready <= (stall_pat % 5 != 2) && ($urandom_range(0, 3) != 0);
        end
    end

    // monitor: compare each result request with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_results.size() == 0) begin
                $display("unexpected result request at %0t", $time);
                error_count++;
            end else begin
                t_result e;
                e = expected_results.pop_front();
                if (res_ch.status != e.status)
                    report_mismatch("status", 32'(res_ch.status), 32'(e.status));
                if (res_ch.slot_index != e.slot_index)
                    report_mismatch("slot_index", 32'(res_ch.slot_index), 32'(e.slot_index));
                if (res_ch.entry_count != e.entry_count)
                    report_mismatch("entry_count", 32'(res_ch.entry_count), 32'(e.entry_count));
                if (res_ch.collision_total != e.collision_total)
                    report_mismatch("collision_total", res_ch.collision_total, e.collision_total);
                if (res_ch.term_total != e.term_total)
                    report_mismatch("term_total", 32'(res_ch.term_total), 32'(e.term_total));
            end
        end
    end

    // end of run and watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else if (i_rst_n && pending_reqs.size() == 0 && !key_ch.valid
                     && expected_results.size() == 0) begin
            drain_cnt <= drain_cnt + 1;
            if (drain_cnt == 300) begin
                if (error_count == 0) $display("Testbench completed without errors");
                else $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end else drain_cnt <= 0;
    end
endmodule
